### rtl/rcc_pkg.sv
// Shared constants and result codes of the reference-counted cache.
`timescale 1ns / 1ps
`default_nettype none
package rcc_pkg;

  localparam int ENTRIES  = 64;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int KEY_BITS = 32;
  localparam int REF_BITS = 8;
  localparam int BYTES_W  = 32;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SIZE_W   = 24;
  localparam int FACTOR_W = 8;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd16777216;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd1;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;

  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNREF    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

endpackage
`default_nettype wire

### rtl/rcc_if.sv
// Request, response and configuration channels of the cache.
`timescale 1ns / 1ps
`default_nettype none
interface rcc_req_if;
  import rcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_BITS-1:0] key_id;
  logic [SIZE_W-1:0]   request_size;
  logic [SLOT_W-1:0]   entry_slot;
  modport source (output valid, kind, key_id, request_size, entry_slot, input ready);
  modport sink (input valid, kind, key_id, request_size, entry_slot, output ready);
endinterface

interface rcc_rsp_if;
  import rcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [REF_BITS-1:0] ref_count;
  logic [BYTES_W-1:0]  free_bytes;
  logic [CNT_W-1:0]    evicted_count;
  logic [CNT_W-1:0]    in_use_count;
  logic [CNT_W-1:0]    released_count;
  logic [31:0]         hit_total;
  modport source (output valid, status, slot, ref_count, free_bytes, evicted_count,
                  in_use_count, released_count, hit_total, input ready);
  modport sink (input valid, status, slot, ref_count, free_bytes, evicted_count,
                in_use_count, released_count, hit_total, output ready);
endinterface

interface rcc_cfg_if;
  import rcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/rcc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/refcounted_cache_with_free_list.sv
// Reference-counted object cache with byte budget and free list of released entries.
//
// Requests come in on req_i (lookup, insert, release), one response per request leaves
// on rsp_o, and cfg_i writes memory_budget, size_factor and size_offset (always ready;
// write only while no request is in flight). Writing memory_budget reloads the free
// byte count.
// One request is worked on at a time; req_i.ready is high only in the idle state.
// Steps per request, counting from acceptance to the response register:
//   lookup:  key memory read, then compare, per slot scanned (up to 64), then response
//   release: reference count read, update, response
//   insert:  charge, check, response; per evicted entry, read head size and link, evict
// The sequential scan of the key memory sets the lookup time, the registered reads of
// the entry memories set the rest.
// The response sits in an output register; a new request is taken while it waits.
// If the next response is ready while the old one is still stalled, the block holds
// until rsp_o.ready. Reset clears the valid bits, counters and free list at once; the
// entry memories need no clearing, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_cache_with_free_list (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rcc_req_if.sink   req_i,
  rcc_rsp_if.source rsp_o,
  rcc_cfg_if.sink   cfg_i
);
  import rcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_RL_RD, S_RL_UPD, S_IN_CHG, S_IN_CHK, S_IN_EV, S_DONE
  } state_e;

  localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(ENTRIES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};

  state_e state_q;

  logic [ENTRIES-1:0]  valid_q;
  logic [SLOT_W-1:0]   head_q, tail_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic [CNT_W-1:0]    used_q, wait_q, ev_q;
  logic [31:0]         hits_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [OFFSET_W-1:0] offset_q;

  logic [KEY_BITS-1:0] key_q;
  logic [SIZE_W-1:0]   size_q;
  logic [SLOT_W-1:0]   rel_q, idx_q;
  logic [BYTES_W-1:0]  charge_q;

  logic [STATUS_W-1:0] res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [REF_BITS-1:0] res_refs_q;

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [SLOT_W-1:0]   rsp_slot_q;
  logic [REF_BITS-1:0] rsp_refs_q;
  logic [BYTES_W-1:0]  rsp_bytes_q;
  logic [CNT_W-1:0]    rsp_ev_q, rsp_used_q, rsp_wait_q;
  logic [31:0]         rsp_hits_q;

  // Entry memories
  logic                key_we, bytes_we, refs_we, next_we, prev_we;
  logic [SLOT_W-1:0]   key_wa, bytes_wa, refs_wa, next_wa, prev_wa;
  logic [SLOT_W-1:0]   key_ra, bytes_ra, refs_ra, next_ra, prev_ra;
  logic [KEY_BITS-1:0] key_wd, key_rd;
  logic [BYTES_W-1:0]  bytes_wd, bytes_rd;
  logic [REF_BITS-1:0] refs_wd, refs_rd;
  logic [SLOT_W-1:0]   next_wd, next_rd, prev_wd, prev_rd;

  rcc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd), .raddr_i(key_ra),
    .rdata_o(key_rd));
  rcc_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_bytes_ram (
    .clk_i, .we_i(bytes_we), .waddr_i(bytes_wa), .wdata_i(bytes_wd), .raddr_i(bytes_ra),
    .rdata_o(bytes_rd));
  rcc_ram #(.WIDTH(REF_BITS), .DEPTH(ENTRIES)) u_refs_ram (
    .clk_i, .we_i(refs_we), .waddr_i(refs_wa), .wdata_i(refs_wd), .raddr_i(refs_ra),
    .rdata_o(refs_rd));
  rcc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd), .raddr_i(next_ra),
    .rdata_o(next_rd));
  rcc_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd), .raddr_i(prev_ra),
    .rdata_o(prev_rd));

  // Lowest empty slot
  logic [SLOT_W-1:0] free_slot;
  logic              full;
  always_comb begin
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end
  assign full = &valid_q;

  logic                lk_hit, rl_ok, evict_go, fits;
  logic [REF_BITS-1:0] ref_inc;
  logic [BYTES_W:0]    charge_sum, reclaim_sum;

  assign lk_hit   = valid_q[idx_q] && (key_rd == key_q);
  assign rl_ok    = valid_q[rel_q] && (refs_rd != '0);
  assign ref_inc  = (refs_rd == REF_MAX) ? refs_rd : refs_rd + 1'b1;
  assign evict_go = (wait_q != '0) && ((bytes_q < charge_q) || full);
  assign fits     = (bytes_q >= charge_q) && !full;
  assign charge_sum  = (BYTES_W+1)'(factor_q * size_q) + (BYTES_W+1)'(offset_q);
  assign reclaim_sum = {1'b0, bytes_q} + {1'b0, bytes_rd};

  always_comb begin
    key_we = 1'b0; bytes_we = 1'b0; refs_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
    key_wa = '0; bytes_wa = '0; refs_wa = '0; next_wa = '0; prev_wa = '0;
    key_wd = '0; bytes_wd = '0; refs_wd = '0; next_wd = '0; prev_wd = '0;
    key_ra = '0; bytes_ra = '0; refs_ra = '0; next_ra = '0; prev_ra = '0;
    case (state_q)
      S_LK_RD: begin
        key_ra = idx_q; refs_ra = idx_q; next_ra = idx_q; prev_ra = idx_q;
      end
      S_LK_CMP: begin
        if (lk_hit) begin
          refs_we = 1'b1; refs_wa = idx_q; refs_wd = ref_inc;
          // pull a released entry off the free list
          if (refs_rd == '0) begin
            if (head_q != idx_q) begin
              next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
            end
            if (tail_q != idx_q) begin
              prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
            end
          end
        end
      end
      S_RL_RD: refs_ra = rel_q;
      S_RL_UPD: begin
        if (rl_ok) begin
          refs_we = 1'b1; refs_wa = rel_q; refs_wd = refs_rd - 1'b1;
          if (refs_rd == REF_BITS'(1)) begin
            prev_we = 1'b1; prev_wa = rel_q; prev_wd = tail_q;
            if (wait_q != '0) begin
              next_we = 1'b1; next_wa = tail_q; next_wd = rel_q;
            end
          end
        end
      end
      S_IN_CHK: begin
        bytes_ra = head_q; next_ra = head_q;
        if (!evict_go && fits) begin
          key_we = 1'b1;   key_wa = free_slot;   key_wd = key_q;
          bytes_we = 1'b1; bytes_wa = free_slot; bytes_wd = charge_q;
          refs_we = 1'b1;  refs_wa = free_slot;  refs_wd = REF_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      head_q <= '0; tail_q <= '0;
      bytes_q <= BUDGET_RESET;
      used_q <= '0; wait_q <= '0; ev_q <= '0;
      hits_q <= '0;
      factor_q <= FACTOR_RESET; offset_q <= OFFSET_RESET;
      key_q <= '0; size_q <= '0; rel_q <= '0; idx_q <= '0;
      charge_q <= '0;
      res_status_q <= '0; res_slot_q <= '0; res_refs_q <= '0;
      rsp_valid_q <= 1'b0;
      rsp_status_q <= '0; rsp_slot_q <= '0; rsp_refs_q <= '0; rsp_bytes_q <= '0;
      rsp_ev_q <= '0; rsp_used_q <= '0; rsp_wait_q <= '0; rsp_hits_q <= '0;
    end else begin
      // the done state reloads the response register itself
      if (rsp_valid_q && rsp_o.ready && state_q != S_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            key_q  <= req_i.key_id;
            size_q <= req_i.request_size;
            rel_q  <= req_i.entry_slot;
            idx_q  <= '0;
            ev_q   <= '0;
            res_status_q <= ST_MISS; res_slot_q <= '0; res_refs_q <= '0;
            case (req_i.kind)
              KIND_LOOKUP:  state_q <= S_LK_RD;
              KIND_INSERT:  state_q <= S_IN_CHG;
              KIND_RELEASE: state_q <= S_RL_RD;
              default:      state_q <= S_DONE;
            endcase
          end
        end
        S_LK_RD: state_q <= S_LK_CMP;
        S_LK_CMP: begin
          if (lk_hit) begin
            hits_q <= hits_q + 1'b1;
            if (refs_rd == '0) begin
              if (head_q == idx_q) head_q <= next_rd;
              if (tail_q == idx_q) tail_q <= prev_rd;
              wait_q <= wait_q - 1'b1;
              used_q <= used_q + 1'b1;
            end
            res_status_q <= ST_HIT; res_slot_q <= idx_q; res_refs_q <= ref_inc;
            state_q <= S_DONE;
          end else if (idx_q == LAST_SLOT) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_LK_RD;
          end
        end
        S_RL_RD: state_q <= S_RL_UPD;
        S_RL_UPD: begin
          if (rl_ok) begin
            res_slot_q <= rel_q;
            if (refs_rd == REF_BITS'(1)) begin
              used_q <= used_q - 1'b1;
              if (wait_q == '0) head_q <= rel_q;
              tail_q <= rel_q;
              wait_q <= wait_q + 1'b1;
              res_status_q <= ST_MOVED; res_refs_q <= '0;
            end else begin
              res_status_q <= ST_DROPPED; res_refs_q <= refs_rd - 1'b1;
            end
          end else begin
            res_status_q <= ST_UNREF;
          end
          state_q <= S_DONE;
        end
        S_IN_CHG: begin
          charge_q <= charge_sum[BYTES_W] ? {BYTES_W{1'b1}} : charge_sum[BYTES_W-1:0];
          state_q <= S_IN_CHK;
        end
        S_IN_CHK: begin
          if (evict_go) begin
            state_q <= S_IN_EV;
          end else begin
            if (fits) begin
              valid_q[free_slot] <= 1'b1;
              used_q <= used_q + 1'b1;
              bytes_q <= bytes_q - charge_q;
              res_status_q <= ST_INSERTED; res_slot_q <= free_slot;
              res_refs_q <= REF_BITS'(1);
            end else begin
              res_status_q <= ST_NO_ROOM;
            end
            state_q <= S_DONE;
          end
        end
        S_IN_EV: begin
          // drop the oldest released entry and reclaim its bytes
          valid_q[head_q] <= 1'b0;
          bytes_q <= reclaim_sum[BYTES_W] ? {BYTES_W{1'b1}} : reclaim_sum[BYTES_W-1:0];
          ev_q <= ev_q + 1'b1;
          wait_q <= wait_q - 1'b1;
          head_q <= next_rd;
          state_q <= S_IN_CHK;
        end
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_slot_q   <= res_slot_q;
            rsp_refs_q   <= res_refs_q;
            rsp_bytes_q  <= bytes_q;
            rsp_ev_q     <= ev_q;
            rsp_used_q   <= used_q;
            rsp_wait_q   <= wait_q;
            rsp_hits_q   <= hits_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_BUDGET: bytes_q  <= cfg_i.data;
          CFG_FACTOR: factor_q <= cfg_i.data[FACTOR_W-1:0];
          CFG_OFFSET: offset_q <= cfg_i.data[OFFSET_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.slot           = rsp_slot_q;
  assign rsp_o.ref_count      = rsp_refs_q;
  assign rsp_o.free_bytes     = rsp_bytes_q;
  assign rsp_o.evicted_count  = rsp_ev_q;
  assign rsp_o.in_use_count   = rsp_used_q;
  assign rsp_o.released_count = rsp_wait_q;
  assign rsp_o.hit_total      = rsp_hits_q;

  a_entry_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, used_q} + {1'b0, wait_q}) <= (CNT_W+1)'(ENTRIES))
    else $error("in-use plus released entries exceed the slot count");

  a_inserted_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q == ST_INSERTED) |-> valid_q[rsp_slot_q])
    else $error("inserted slot not valid while its response waits");

  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IN_EV) |-> ($past(wait_q) != '0 && wait_q != '0))
    else $error("eviction from an empty free list");

endmodule
`default_nettype wire

### verif/rcc_cache_checker.sv
// Predicts cache responses from observed requests and compares them with the block's output.
`timescale 1ns / 1ps
module rcc_cache_checker
  import rcc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  rcc_req_if.sink  req_mon,
  rcc_rsp_if.sink  rsp_mon,
  rcc_cfg_if.sink  cfg_mon,
  output int       fail_count,
  output int       pending_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [REF_BITS-1:0] ref_count;
    logic [BYTES_W-1:0]  free_bytes;
    logic [CNT_W-1:0]    evicted_count;
    logic [CNT_W-1:0]    in_use_count;
    logic [CNT_W-1:0]    released_count;
    logic [31:0]         hit_total;
  } cache_rsp_t;

  cache_rsp_t expected_rsps[$];

  logic [FACTOR_W-1:0] factor_q;
  logic [OFFSET_W-1:0] offset_q;
  bit                  slot_valid[ENTRIES];
  logic [KEY_BITS-1:0] slot_key[ENTRIES];
  logic [31:0]         slot_bytes[ENTRIES];
  int unsigned         slot_refs[ENTRIES];
  int unsigned         next_link[ENTRIES];
  int unsigned         prev_link[ENTRIES];
  int unsigned         head_q, tail_q, in_use_q, waiting_q;
  logic [31:0]         free_q, hits_q;

  assign pending_count = expected_rsps.size();

  function automatic void unlink_slot(int unsigned s);
    if (head_q == s) head_q = next_link[s];
    else next_link[prev_link[s] % ENTRIES] = next_link[s];
    if (tail_q == s) tail_q = prev_link[s];
    else prev_link[next_link[s] % ENTRIES] = prev_link[s];
    waiting_q--;
  endfunction

  function automatic int first_empty();
    for (int i = 0; i < ENTRIES; i++) if (!slot_valid[i]) return i;
    return -1;
  endfunction

  function automatic cache_rsp_t predict_rsp(logic [KIND_W-1:0] kind, logic [31:0] key,
                                             logic [SIZE_W-1:0] req_size,
                                             logic [SLOT_W-1:0] rel);
    cache_rsp_t r;
    longint unsigned charge64, sum;
    logic [31:0] charge;
    int empty, found, s;
    r = '0;
    r.status = ST_MISS;
    if (kind == KIND_LOOKUP) begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_key[i] == key) begin
          found = i;
          break;
        end
      end
      if (found >= 0) begin
        hits_q++;
        if (slot_refs[found] == 0) begin
          unlink_slot(found);
          in_use_q++;
        end
        if (slot_refs[found] < (1 << REF_BITS) - 1) slot_refs[found]++;
        r.status = ST_HIT;
        r.slot = SLOT_W'(found);
        r.ref_count = REF_BITS'(slot_refs[found]);
      end
    end else if (kind == KIND_INSERT) begin
      charge64 = longint'(factor_q) * longint'(req_size) + longint'(offset_q);
      charge = charge64 > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : charge64[31:0];
      empty = first_empty();
      while (waiting_q > 0 && (free_q < charge || empty < 0)) begin
        s = head_q % ENTRIES;
        unlink_slot(s);
        slot_valid[s] = 0;
        sum = longint'(free_q) + longint'(slot_bytes[s]);
        free_q = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
        r.evicted_count++;
        if (empty < 0) empty = s;
      end
      if (free_q >= charge && empty >= 0) begin
        s = first_empty();
        slot_valid[s] = 1;
        slot_key[s] = key;
        slot_bytes[s] = charge;
        slot_refs[s] = 1;
        next_link[s] = 0;
        prev_link[s] = 0;
        in_use_q++;
        free_q -= charge;
        r.status = ST_INSERTED;
        r.slot = SLOT_W'(s);
        r.ref_count = REF_BITS'(1);
      end else begin
        r.status = ST_NO_ROOM;
      end
    end else if (kind == KIND_RELEASE) begin
      r.status = ST_UNREF;
      if (slot_valid[rel] && slot_refs[rel] > 0) begin
        if (slot_refs[rel] == 1) begin
          slot_refs[rel] = 0;
          in_use_q--;
          if (waiting_q == 0) head_q = rel;
          else next_link[tail_q % ENTRIES] = rel;
          prev_link[rel] = tail_q;
          next_link[rel] = 0;
          tail_q = rel;
          waiting_q++;
          r.status = ST_MOVED;
        end else begin
          slot_refs[rel]--;
          r.status = ST_DROPPED;
        end
        r.slot = rel;
        r.ref_count = REF_BITS'(slot_refs[rel]);
      end
    end
    r.free_bytes = free_q;
    r.in_use_count = CNT_W'(in_use_q);
    r.released_count = CNT_W'(waiting_q);
    r.hit_total = hits_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_rsp_t exp_rsp, got;
    if (!rst_ni) begin
      factor_q = FACTOR_RESET;
      offset_q = OFFSET_RESET;
      free_q = BUDGET_RESET;
      hits_q = 0;
      head_q = 0;
      tail_q = 0;
      in_use_q = 0;
      waiting_q = 0;
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 0;
      expected_rsps.delete();
      fail_count = 0;
    end else begin
      // compare before predicting: a response never stems from the same-edge request
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.status, rsp_mon.slot, rsp_mon.ref_count, rsp_mon.free_bytes,
                rsp_mon.evicted_count, rsp_mon.in_use_count, rsp_mon.released_count,
                rsp_mon.hit_total};
        if (expected_rsps.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response %p", $time, got);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got !== exp_rsp) begin
            fail_count++;
            $display("%0t: response mismatch expected %p actual %p", $time, exp_rsp, got);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BUDGET: free_q = cfg_mon.data;
          CFG_FACTOR: factor_q = cfg_mon.data[FACTOR_W-1:0];
          CFG_OFFSET: offset_q = cfg_mon.data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        expected_rsps.push_back(predict_rsp(req_mon.kind, req_mon.key_id,
                                            req_mon.request_size, req_mon.entry_slot));
    end
  end

endmodule

### verif/refcounted_cache_with_free_list_tb.sv
// Stimulus and verdict for the reference-counted cache.
`timescale 1ns / 1ps
module refcounted_cache_with_free_list_tb;
  import rcc_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending_count;
  bit   rsp_hold;

  rcc_req_if req_ch();
  rcc_rsp_if rsp_ch();
  rcc_cfg_if cfg_ch();

  refcounted_cache_with_free_list u_top (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  rcc_cache_checker u_checker (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending_count(pending_count)
  );

  logic [31:0] key_pool[8];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** refcounted_cache_with_free_list: FAILED **");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    int n;
    rsp_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_hold) begin
        rsp_ch.ready <= 0;
        repeat (299) @(negedge clk_i);
        rsp_hold = 0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          rsp_ch.ready <= 0;
          repeat (n - 1) @(negedge clk_i);
        end else begin
          rsp_ch.ready <= 1;
          repeat ($urandom_range(0, 6)) begin
            @(negedge clk_i);
            if (rsp_hold) break;
          end
        end
      end
    end
  end

  // Valid stays high after acceptance until the next request or a pause drops it.
  task automatic send_req(logic [KIND_W-1:0] kind, logic [31:0] key,
                          logic [SIZE_W-1:0] sz, logic [SLOT_W-1:0] rel, bit idle_gap);
    int n;
    n = idle_gap ? gap_len() : 0;
    if (n > 0) begin
      req_ch.valid <= 0;
      repeat (n) @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.kind <= kind;
    req_ch.key_id <= key;
    req_ch.request_size <= sz;
    req_ch.entry_slot <= rel;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_empty();
    req_ch.valid <= 0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic drain();
    wait_empty();
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 0;
    @(negedge clk_i);
  endtask

  task automatic random_req(int kind_bias);
    int p;
    logic [SIZE_W-1:0] sz;
    p = $urandom_range(0, 99);
    sz = ($urandom_range(0, 19) == 0) ? SIZE_W'($urandom()) :
         SIZE_W'($urandom_range(0, 4000));
    if (p < 30)
      send_req(KIND_INSERT, key_pool[$urandom_range(0, 7)], sz, '0, 1'b1);
    else if (p < 55)
      send_req(KIND_LOOKUP, ($urandom_range(0, 9) == 0) ? $urandom() :
               key_pool[$urandom_range(0, 7)], SIZE_W'($urandom()),
               SLOT_W'($urandom()), 1'b1);
    else if (p < 95 - kind_bias)
      send_req(KIND_RELEASE, $urandom(), SIZE_W'($urandom()),
               SLOT_W'($urandom_range(0, 63)), 1'b1);
    else
      send_req(2'd3, $urandom(), SIZE_W'($urandom()), SLOT_W'($urandom()), 1'b1);
  endtask

  initial begin
    rst_ni = 0;
    rsp_hold = 0;
    req_ch.valid = 0;
    req_ch.kind = KIND_LOOKUP;
    req_ch.key_id = 0;
    req_ch.request_size = 0;
    req_ch.entry_slot = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_BUDGET;
    cfg_ch.data = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, every kind, bad release, duplicate keys, overflows.
    send_req(KIND_LOOKUP, 32'h0, 0, 0, 0);
    send_req(KIND_INSERT, 32'h0, 24'hFFFFFF, 0, 0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, 24'd100, 0, 0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, 24'd0, 0, 0);
    send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 24'hFFFFFF, 6'h3F, 0);
    send_req(KIND_RELEASE, 0, 0, 6'h3F, 0);
    send_req(KIND_RELEASE, 0, 0, 6'd1, 0);
    send_req(KIND_RELEASE, 0, 0, 6'd1, 0);
    send_req(KIND_RELEASE, 0, 0, 6'd1, 0);
    send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
    send_req(2'd3, 32'hA5A5_5A5A, 24'hFFFFFF, 6'h3F, 0);
    // count ceiling: 256 hits on one entry
    repeat (256) send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
    drain();

    write_reg(CFG_FACTOR, 32'hFF);
    write_reg(CFG_OFFSET, 32'hFFFF);
    write_reg(CFG_BUDGET, 32'hFFFF_FFFF);
    send_req(KIND_INSERT, 32'h1234, 24'hFFFFFF, 0, 0);
    send_req(KIND_INSERT, 32'h5678, 24'hFFFFFF, 0, 0);
    send_req(KIND_RELEASE, 0, 0, 6'd2, 0);
    send_req(KIND_INSERT, 32'h9ABC, 24'hFFFFFF, 0, 0);
    drain();
    // near-full budget: release the big one, then insert another big one
    write_reg(CFG_BUDGET, 32'hFFFF_FFF0);
    send_req(KIND_RELEASE, 0, 0, 6'd2, 0);
    send_req(KIND_INSERT, 32'h1, 24'hFFFFFF, 0, 0);
    drain();

    // Random phases across several settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_BUDGET, 32'd20000); write_reg(CFG_FACTOR, 1);
                 write_reg(CFG_OFFSET, 0); end
        1: begin write_reg(CFG_BUDGET, 32'd0); write_reg(CFG_FACTOR, 1);
                 write_reg(CFG_OFFSET, 0); end
        2: begin write_reg(CFG_BUDGET, 32'd60000); write_reg(CFG_FACTOR, 3);
                 write_reg(CFG_OFFSET, 100); end
        3: begin write_reg(CFG_BUDGET, 32'hFFFF_FFFF); write_reg(CFG_FACTOR, 1);
                 write_reg(CFG_OFFSET, 1); end
        4: begin write_reg(CFG_BUDGET, $urandom()); write_reg(CFG_FACTOR, $urandom());
                 write_reg(CFG_OFFSET, $urandom()); end
        default: begin write_reg(CFG_BUDGET, 32'd150000); write_reg(CFG_FACTOR, 17);
                 write_reg(CFG_OFFSET, 65535); end
      endcase
      for (int i = 0; i < 190; i++) begin
        if (ph == 2 && i == 40) rsp_hold = 1;
        if (ph == 3 && i == 90) wait_empty();
        random_req(ph == 3 ? 20 : 0);
      end
      drain();
    end
    if (fail_count == 0)
      $display("** refcounted_cache_with_free_list: PASSED **");
    else
      $display("** refcounted_cache_with_free_list: FAILED **");
    $finish;
  end

endmodule
